[src/periodic_timer_task_queue_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the periodic timer task queue
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TASK_QUEUE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TASK_QUEUE_UNIT_DEFINES_SVH

// Property checked at every edge out of reset.
`define PTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define PTQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/ptq_pkg.sv]
// ---------------------------------------------------------------------------
// Timer task queue package
// Field widths, codes, state encoding and shared structures.
// ---------------------------------------------------------------------------
package ptq_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned JOB_W    = 8;
  localparam int unsigned DLY_W    = 24;
  localparam int unsigned DSLOT_W  = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OSLOT_W  = 4;
  localparam int unsigned TK_W     = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MAX_OUT  = 16;
  localparam int unsigned N_W      = $clog2(MAX_OUT + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 3'd0,
    MODE_ONCE  = 3'd1,
    MODE_RATE  = 3'd2,
    MODE_DELAY = 3'd3,
    MODE_DONE  = 3'd4,
    MODE_STOP  = 3'd5
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_e;

  localparam logic [TK_W-1:0] TK_ONCE  = 2'd0;
  localparam logic [TK_W-1:0] TK_RATE  = 2'd1;
  localparam logic [TK_W-1:0] TK_DELAY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_SCHED,
    ST_SCAN,
    ST_DECIDE,
    ST_FLUSH,
    ST_DONE_RD,
    ST_DONE_WR
  } st_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [JOB_W-1:0]   job_id;
    logic [DLY_W-1:0]   delay;
    logic [DLY_W-1:0]   period;
    logic [DSLOT_W-1:0] done_slot;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [JOB_W-1:0]   job;
    logic [OSLOT_W-1:0] slot;
    logic [TK_W-1:0]    tk;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] cmp;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              gt;
  } alu_rsp_t;

endpackage

[src/ptq_if.sv]
// ---------------------------------------------------------------------------
// Timer task queue channels
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ptq_in_if import ptq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [JOB_W-1:0]   job_id;
  logic [DLY_W-1:0]   delay;
  logic [DLY_W-1:0]   period;
  logic [DSLOT_W-1:0] done_slot;

  modport source (output valid, mode, job_id, delay, period, done_slot, input ready);
  modport sink   (input valid, mode, job_id, delay, period, done_slot, output ready);
endinterface

interface ptq_out_if import ptq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [JOB_W-1:0]   out_job_id;
  logic [OSLOT_W-1:0] out_slot;
  logic [TK_W-1:0]    task_kind;
  logic               last;

  modport source (output valid, kind, out_job_id, out_slot, task_kind, last, input ready);
  modport sink   (input valid, kind, out_job_id, out_slot, task_kind, last, output ready);
endinterface

[src/ptq_alu.sv]
// ---------------------------------------------------------------------------
// Timer task queue arithmetic unit
// Shared 32-bit add/subtract with a magnitude compare on the result.
// ---------------------------------------------------------------------------
module ptq_alu import ptq_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [TIME_W-1:0] sum;

  assign sum       = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
  assign rsp_o.sum = sum;
  assign rsp_o.gt  = (sum > req_i.cmp);

endmodule

[src/ptq_seq.sv]
// ---------------------------------------------------------------------------
// Timer task queue sequencer
// Slot table, time counter and the control that steps the shared unit.
// ---------------------------------------------------------------------------
module ptq_seq import ptq_pkg::*; #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DELAY_BITS = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  item_t    item_i,
  input  logic     out_free_i,
  output logic     emit_o,
  output res_t     res_o,
  output alu_req_t alu_req_o,
  input  alu_rsp_t alu_rsp_i
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = SW + 1;
  localparam int unsigned PW = (DELAY_BITS < DLY_W) ? DELAY_BITS : DLY_W;
  localparam int unsigned XW = SW + DSLOT_W;

  typedef struct packed {
    logic [TK_W-1:0]   tk;
    logic [TIME_W-1:0] due;
    logic [PW-1:0]     per;
    logic [JOB_W-1:0]  job;
  } slot_t;

  function automatic logic [OSLOT_W-1:0] slot4(input logic [SW-1:0] s);
    logic [SW+OSLOT_W-1:0] w;
    w = (SW + OSLOT_W)'(s);
    return w[OSLOT_W-1:0];
  endfunction

  // control state
  st_e              st_q, st_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic             stopped_q, stopped_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] parked_q, parked_d;
  logic [SLOTS-1:0] fired_q, fired_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             pipe_vld_q, pipe_vld_d;
  logic             found_q, found_d;
  logic             pend_vld_q, pend_vld_d;
  logic [N_W-1:0]   n_q, n_d;

  // payload
  logic [JOB_W-1:0]  job_q, job_d;
  logic [PW-1:0]     dly_q, dly_d;
  logic [PW-1:0]     per_q, per_d;
  logic [TK_W-1:0]   tk_q, tk_d;
  logic [SW-1:0]     didx_q, didx_d;
  logic [SW-1:0]     pipe_idx_q, pipe_idx_d;
  logic [SW-1:0]     best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_late_q, best_late_d;
  slot_t             best_q, best_d;
  res_t              pend_q, pend_d;

  // slot table
  slot_t   mem_q [SLOTS];
  slot_t   rd_q;
  logic    wr_en;
  logic [SW-1:0] wr_addr, rd_addr;
  slot_t   wr_data;

  // completion slot decode
  logic [XW-1:0] done_w;
  logic          done_in_range;
  logic [SW-1:0] done_idx;
  logic [PW-1:0] per_in;
  logic          elig;

  assign done_w        = XW'(item_i.done_slot);
  assign done_in_range = (done_w < XW'(SLOTS));
  assign done_idx      = done_w[SW-1:0];
  assign per_in        = item_i.period[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      now_q      <= '0;
      stopped_q  <= 1'b0;
      valid_q    <= '0;
      parked_q   <= '0;
      fired_q    <= '0;
      idx_q      <= '0;
      pipe_vld_q <= 1'b0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      n_q        <= '0;
    end else begin
      st_q       <= st_d;
      now_q      <= now_d;
      stopped_q  <= stopped_d;
      valid_q    <= valid_d;
      parked_q   <= parked_d;
      fired_q    <= fired_d;
      idx_q      <= idx_d;
      pipe_vld_q <= pipe_vld_d;
      found_q    <= found_d;
      pend_vld_q <= pend_vld_d;
      n_q        <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    dly_q       <= dly_d;
    per_q       <= per_d;
    tk_q        <= tk_d;
    didx_q      <= didx_d;
    pipe_idx_q  <= pipe_idx_d;
    best_idx_q  <= best_idx_d;
    best_late_q <= best_late_d;
    best_q      <= best_d;
    pend_q      <= pend_d;
  end

  always_comb begin
    st_d        = st_q;
    now_d       = now_q;
    stopped_d   = stopped_q;
    valid_d     = valid_q;
    parked_d    = parked_q;
    fired_d     = fired_q;
    idx_d       = idx_q;
    pipe_vld_d  = pipe_vld_q;
    found_d     = found_q;
    pend_vld_d  = pend_vld_q;
    n_d         = n_q;
    job_d       = job_q;
    dly_d       = dly_q;
    per_d       = per_q;
    tk_d        = tk_q;
    didx_d      = didx_q;
    pipe_idx_d  = pipe_idx_q;
    best_idx_d  = best_idx_q;
    best_late_d = best_late_q;
    best_d      = best_q;
    pend_d      = pend_q;
    wr_en       = 1'b0;
    wr_addr     = best_idx_q;
    wr_data     = best_q;
    rd_addr     = idx_q[SW-1:0];
    alu_req_o.a   = now_q;
    alu_req_o.b   = '0;
    alu_req_o.cmp = best_late_q;
    alu_req_o.sub = 1'b0;
    emit_o      = 1'b0;
    res_o       = pend_q;
    in_ready_o  = (st_q == ST_IDLE);
    elig        = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          job_d  = item_i.job_id;
          dly_d  = item_i.delay[PW-1:0];
          per_d  = (per_in == '0) ? PW'(1) : per_in;
          tk_d   = TK_W'(item_i.mode - MODE_W'(MODE_ONCE));
          didx_d = done_idx;
          pend_d      = '0;
          pend_d.kind = KIND_IGNORE;
          case (item_i.mode)
            MODE_TICK: begin
              alu_req_o.b = TIME_W'(1);
              now_d       = alu_rsp_i.sum;
              fired_d     = '0;
              if (!stopped_q) begin
                st_d       = ST_SCAN;
                idx_d      = '0;
                pipe_vld_d = 1'b0;
                found_d    = 1'b0;
                pend_vld_d = 1'b0;
                n_d        = '0;
              end
            end
            MODE_ONCE, MODE_RATE, MODE_DELAY: begin
              if (stopped_q) begin
                st_d = ST_FLUSH;
              end else begin
                idx_d = '0;
                st_d  = ST_FREE;
              end
            end
            MODE_DONE: begin
              if (!stopped_q && done_in_range && valid_q[done_idx] && parked_q[done_idx]) begin
                st_d = ST_DONE_RD;
              end else begin
                st_d = ST_FLUSH;
              end
            end
            MODE_STOP: begin
              stopped_d = 1'b1;
              valid_d   = '0;
              parked_d  = '0;
            end
            default: begin
              st_d = ST_FLUSH;
            end
          endcase
        end
      end

      ST_FREE: begin
        if (idx_q == CW'(SLOTS)) begin
          pend_d.kind = KIND_REJECT;
          pend_d.job  = job_q;
          pend_d.slot = '0;
          pend_d.tk   = tk_q;
          st_d        = ST_FLUSH;
        end else if (!valid_q[idx_q[SW-1:0]]) begin
          st_d = ST_SCHED;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      ST_SCHED: begin
        alu_req_o.b = TIME_W'(dly_q);
        wr_en       = 1'b1;
        wr_addr     = idx_q[SW-1:0];
        wr_data.tk  = tk_q;
        wr_data.due = alu_rsp_i.sum;
        wr_data.per = per_q;
        wr_data.job = job_q;
        valid_d[idx_q[SW-1:0]]  = 1'b1;
        parked_d[idx_q[SW-1:0]] = 1'b0;
        pend_d.kind = KIND_ACCEPT;
        pend_d.job  = job_q;
        pend_d.slot = slot4(idx_q[SW-1:0]);
        pend_d.tk   = tk_q;
        st_d        = ST_FLUSH;
      end

      ST_SCAN: begin
        // issue one read a cycle, judge the slot read the cycle before
        alu_req_o.b   = rd_q.due;
        alu_req_o.sub = 1'b1;
        if (idx_q != CW'(SLOTS)) begin
          idx_d      = idx_q + CW'(1);
          pipe_vld_d = 1'b1;
          pipe_idx_d = idx_q[SW-1:0];
        end else begin
          pipe_vld_d = 1'b0;
          st_d       = ST_DECIDE;
        end
        elig = pipe_vld_q && valid_q[pipe_idx_q] && !parked_q[pipe_idx_q] &&
               !fired_q[pipe_idx_q] && !alu_rsp_i.sum[TIME_W-1];
        if (elig && (!found_q || alu_rsp_i.gt)) begin
          found_d     = 1'b1;
          best_idx_d  = pipe_idx_q;
          best_late_d = alu_rsp_i.sum;
          best_d      = rd_q;
        end
      end

      ST_DECIDE: begin
        if (out_free_i || !pend_vld_q) begin
          if (found_q) begin
            fired_d[best_idx_q] = 1'b1;
            case (best_q.tk)
              TK_ONCE: valid_d[best_idx_q] = 1'b0;
              TK_RATE: begin
                alu_req_o.a = best_q.due;
                alu_req_o.b = TIME_W'(best_q.per);
                wr_en       = 1'b1;
                wr_data.due = alu_rsp_i.sum;
              end
              default: parked_d[best_idx_q] = 1'b1;
            endcase
            if (pend_vld_q) begin
              emit_o     = 1'b1;
              res_o.last = 1'b0;
            end
            pend_d.kind = KIND_FIRED;
            pend_d.job  = best_q.job;
            pend_d.slot = slot4(best_idx_q);
            pend_d.tk   = best_q.tk;
            pend_vld_d  = 1'b1;
            n_d         = n_q + N_W'(1);
            if (n_d == N_W'(MAX_OUT)) begin
              st_d = ST_FLUSH;
            end else begin
              st_d       = ST_SCAN;
              idx_d      = '0;
              found_d    = 1'b0;
              pipe_vld_d = 1'b0;
            end
          end else begin
            if (pend_vld_q) begin
              emit_o     = 1'b1;
              res_o.last = 1'b1;
            end
            pend_vld_d = 1'b0;
            st_d       = ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free_i) begin
          emit_o     = 1'b1;
          res_o.last = 1'b1;
          pend_vld_d = 1'b0;
          st_d       = ST_IDLE;
        end
      end

      ST_DONE_RD: begin
        rd_addr = didx_q;
        st_d    = ST_DONE_WR;
      end

      ST_DONE_WR: begin
        if (rd_q.tk == TK_DELAY) begin
          alu_req_o.b      = TIME_W'(rd_q.per);
          wr_en            = 1'b1;
          wr_addr          = didx_q;
          wr_data          = rd_q;
          wr_data.due      = alu_rsp_i.sum;
          parked_d[didx_q] = 1'b0;
          st_d             = ST_IDLE;
        end else begin
          st_d = ST_FLUSH;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

endmodule

[src/periodic_timer_task_queue_unit.sv]
// ---------------------------------------------------------------------------
// Periodic timer task queue
// Table of one-time, fixed-rate and fixed-delay tasks driven by ms ticks.
// ---------------------------------------------------------------------------
//  channel | dir | transaction
//  req_i   | in  | mode, job_id, delay, period, done_slot
//  res_o   | out | kind, out_job_id, out_slot, task_kind, last
//
//  Tick: one compare of the shared unit per slot per round and one fire per
//  round, up to the cap of 16 fires; a tick once stopped does not scan.
//  Schedule: free-slot walk.
//  Reset clears time, stop flag and the valid/parked bits; no clearing pass.
//  A held result on res_o stalls the sequencer only when it must emit.
// ---------------------------------------------------------------------------
module periodic_timer_task_queue_unit import ptq_pkg::*; #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DELAY_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptq_in_if.sink     req_i,
  ptq_out_if.source  res_o
);

  item_t    item;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     out_free;
  logic     emit;
  res_t     res;
  logic     in_ready;

  // output register state
  logic out_vld_q, out_vld_d;
  res_t res_q;

  assign item.mode      = req_i.mode;
  assign item.job_id    = req_i.job_id;
  assign item.delay     = req_i.delay;
  assign item.period    = req_i.period;
  assign item.done_slot = req_i.done_slot;
  assign req_i.ready    = in_ready;

  // sequencer owns the table and steps the shared unit
  ptq_seq #(
    .SLOTS      (SLOTS),
    .DELAY_BITS (DELAY_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .item_i     (item),
    .out_free_i (out_free),
    .emit_o     (emit),
    .res_o      (res),
    .alu_req_o  (alu_req),
    .alu_rsp_i  (alu_rsp)
  );

  // single adder/comparator shared by all arithmetic steps
  ptq_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // result register: free when empty or being taken this cycle
  assign out_free = !out_vld_q || res_o.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.kind       = res_q.kind;
  assign res_o.out_job_id = res_q.job;
  assign res_o.out_slot   = res_q.slot;
  assign res_o.task_kind  = res_q.tk;
  assign res_o.last       = res_q.last;

endmodule

[src/ptq_chk.sv]
// ---------------------------------------------------------------------------
// Timer task queue port checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "periodic_timer_task_queue_unit_defines.svh"

module ptq_chk import ptq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [KIND_W-1:0]  out_kind_i,
  input logic [JOB_W-1:0]   out_job_i,
  input logic [OSLOT_W-1:0] out_slot_i,
  input logic [TK_W-1:0]    out_tk_i,
  input logic               out_last_i
);

  `PTQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_job_i) && $stable(out_slot_i) && $stable(out_last_i), "ptq: stalled result changed")

  `PTQ_ASSERT(a_ignore_zero, out_valid_i && out_kind_i == KIND_IGNORE |-> out_job_i == '0 && out_slot_i == '0 && out_tk_i == '0, "ptq: ignored result not cleared")

  `PTQ_ASSERT(a_single_last, out_valid_i && out_kind_i != KIND_FIRED |-> out_last_i, "ptq: non-fire result not last")

  `PTQ_ASSERT(a_reject_slot, out_valid_i && out_kind_i == KIND_REJECT |-> out_slot_i == '0, "ptq: rejected result carries a slot")

endmodule

bind periodic_timer_task_queue_unit ptq_chk u_ptq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_kind_i  (res_o.kind),
  .out_job_i   (res_o.out_job_id),
  .out_slot_i  (res_o.out_slot),
  .out_tk_i    (res_o.task_kind),
  .out_last_i  (res_o.last)
);
